// ===== rtl/core/fixed_width_radix_formatter_defines.svh =====
// Assertion macros shared by the fixed-width radix formatter RTL.
`ifndef FIXED_WIDTH_RADIX_FORMATTER_DEFINES_SVH
`define FIXED_WIDTH_RADIX_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FWRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fwrf: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define FWRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fwrf: next-cycle implication failed");

`endif

// ===== rtl/core/fwrf_pkg.sv =====
// Shared constants, types and the glyph function of the radix formatter.
package fwrf_pkg;

	localparam int unsigned DEF_VALUE_WIDTH = 32;
	localparam int unsigned DEF_MAX_DIGITS  = 32;
	localparam int unsigned CHUNK_W         = 8;
	localparam int unsigned RADIX_W         = 5;
	localparam int unsigned COUNT_W         = 6;
	localparam int unsigned DIGIT_W         = 4;
	localparam int unsigned CHAR_W          = 7;
	localparam int unsigned REG_W           = 32;
	localparam int unsigned PADDR_W         = 3;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd10;

	typedef enum logic [0:0] {
		REG_RADIX = 1'b0,
		REG_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic step;
		logic first;
		logic zero;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic num_zero;
	} sts_t;

	// Digits 0 to 9 become '0' to '9', 10 to 15 become 'A' to 'F'.
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = 7'h30 + {3'b000, d};
		end else begin
			c = 7'h37 + {3'b000, d};
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/fwrf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fwrf_ram #(
	parameter int unsigned WIDTH = fwrf_pkg::DIGIT_W,
	parameter int unsigned DEPTH = fwrf_pkg::DEF_MAX_DIGITS,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/fwrf_regs.sv =====
// Configuration registers of the radix formatter and their effective values.
module fwrf_regs #(
	parameter int unsigned MAX_DIGITS = fwrf_pkg::DEF_MAX_DIGITS,
	parameter int unsigned AW         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fwrf_pkg::PADDR_W-1:0]     paddr,
	input  logic [fwrf_pkg::REG_W-1:0]       pwdata,
	output logic [fwrf_pkg::REG_W-1:0]       prdata,
	output logic                             pready,
	output logic [fwrf_pkg::RADIX_W-1:0]     eff_radix,
	output logic [AW-1:0]                    last_idx
);

	localparam int unsigned CW1 = fwrf_pkg::COUNT_W + 1;

	logic [fwrf_pkg::RADIX_W-1:0] radix_q;
	logic [fwrf_pkg::COUNT_W-1:0] count_q;
	logic [CW1-1:0]               cnt;
	fwrf_pkg::reg_idx_t           idx;

	assign pready = 1'b1;
	assign idx    = fwrf_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= fwrf_pkg::RADIX_RESET;
			count_q <= fwrf_pkg::COUNT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				fwrf_pkg::REG_RADIX: radix_q <= pwdata[fwrf_pkg::RADIX_W-1:0];
				fwrf_pkg::REG_COUNT: count_q <= pwdata[fwrf_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fwrf_pkg::REG_RADIX: prdata = fwrf_pkg::REG_W'(radix_q);
			fwrf_pkg::REG_COUNT: prdata = fwrf_pkg::REG_W'(count_q);
			default:             prdata = '0;
		endcase
	end

	// Out-of-range bases saturate to the nearest legal one.
	always_comb begin
		if (radix_q < fwrf_pkg::RADIX_MIN) begin
			eff_radix = fwrf_pkg::RADIX_MIN;
		end else if (radix_q > fwrf_pkg::RADIX_MAX) begin
			eff_radix = fwrf_pkg::RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	// A count of zero emits one character; counts above the store depth are clipped.
	always_comb begin
		cnt = CW1'(count_q);
		if (cnt == '0) begin
			cnt = CW1'(1);
		end else if (cnt > CW1'(MAX_DIGITS)) begin
			cnt = CW1'(MAX_DIGITS);
		end
		last_idx = AW'(cnt - CW1'(1));
	end

endmodule

// ===== rtl/core/fwrf_dpath.sv =====
// Datapath: the value register and a divider that retires eight bits per cycle.
module fwrf_dpath #(
	parameter int unsigned VALUE_WIDTH = fwrf_pkg::DEF_VALUE_WIDTH,
	parameter int unsigned NCHUNK      = (VALUE_WIDTH + fwrf_pkg::CHUNK_W - 1) / fwrf_pkg::CHUNK_W,
	parameter int unsigned PW          = NCHUNK * fwrf_pkg::CHUNK_W
) (
	input  logic                         clk,
	input  fwrf_pkg::cmd_t               cmd,
	input  logic [VALUE_WIDTH-1:0]       value,
	input  logic [fwrf_pkg::RADIX_W-1:0] radix,
	output fwrf_pkg::sts_t               sts,
	output logic [fwrf_pkg::DIGIT_W-1:0] wdata
);

	localparam int unsigned CK = fwrf_pkg::CHUNK_W;
	localparam int unsigned RW = fwrf_pkg::RADIX_W;

	logic [PW-1:0] num_q;
	logic [PW-1:0] num_rot;
	logic [RW-1:0] base_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] rem_next;
	logic [CK-1:0] quo;

	// Long division of the top chunk, one quotient bit per step.
	always_comb begin
		logic [CK-1:0] top;
		logic [RW-1:0] r;
		logic [RW:0]   t;
		top = num_q[PW-1 -: CK];
		r   = cmd.first ? '0 : rem_q;
		quo = '0;
		for (int i = CK - 1; i >= 0; i--) begin
			t = {r, top[i]};
			if (t >= {1'b0, base_q}) begin
				t      = t - {1'b0, base_q};
				quo[i] = 1'b1;
			end
			r = t[RW-1:0];
		end
		rem_next = r;
	end

	// The quotient chunk enters at the bottom, so after a full pass the
	// register holds the whole quotient in place.
	generate
		if (PW > CK) begin : g_rot
			assign num_rot = {num_q[PW-CK-1:0], quo};
		end else begin : g_one
			assign num_rot = quo;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= PW'(value);
			base_q <= radix;
		end else if (cmd.step) begin
			num_q <= num_rot;
			rem_q <= rem_next;
		end
	end

	assign sts.num_zero = (num_q == '0);
	assign wdata        = cmd.zero ? '0 : rem_next[fwrf_pkg::DIGIT_W-1:0];

endmodule

// ===== rtl/core/fwrf_ctrl.sv =====
// Controller: sequences load, digit extraction and character output.
`include "fixed_width_radix_formatter_defines.svh"
module fwrf_ctrl #(
	parameter int unsigned NCHUNK = 4,
	parameter int unsigned AW     = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic           m_tlast,
	input  logic [AW-1:0]  last_idx,
	input  fwrf_pkg::sts_t sts,
	output fwrf_pkg::cmd_t cmd,
	output logic [AW-1:0]  wr_addr,
	output logic           rd_en,
	output logic [AW-1:0]  rd_addr
);

	localparam int unsigned CW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIVIDE = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_SHOW   = 4'b1000
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] chunk_q;
	logic [AW-1:0] dig_q;
	logic [AW-1:0] rd_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_SHOW);
	assign m_tlast  = (rd_q == '0);
	assign wr_addr  = dig_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		rd_en   = 1'b0;
		rd_addr = rd_q - AW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				// Once the quotient is zero every further digit is zero.
				if ((chunk_q == '0) && sts.num_zero) begin
					cmd.zero  = 1'b1;
					cmd.write = 1'b1;
				end else begin
					cmd.step  = 1'b1;
					cmd.first = (chunk_q == '0);
					cmd.write = (chunk_q == CW'(NCHUNK - 1));
				end
				if (cmd.write && (dig_q == last_idx)) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (m_tready) begin
					if (rd_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
			dig_q   <= '0;
			rd_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				chunk_q <= '0;
				dig_q   <= '0;
			end else if (cmd.write) begin
				chunk_q <= '0;
				dig_q   <= dig_q + AW'(1);
			end else if (cmd.step) begin
				chunk_q <= chunk_q + CW'(1);
			end
			if (rd_en) begin
				rd_q <= rd_addr;
			end
		end
	end

	`FWRF_ASSERT_IMP(a_write_in_divide, clk, arst_n, cmd.write, state_q == ST_DIVIDE)
	`FWRF_ASSERT_NXT(a_accept_divides, clk, arst_n, s_tvalid && s_tready, state_q == ST_DIVIDE)
	`FWRF_ASSERT_NXT(a_last_frees_input, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready)
	`FWRF_ASSERT_NXT(a_stall_holds_ptr, clk, arst_n, m_tvalid && !m_tready, $stable(rd_q) && m_tvalid)

endmodule

// ===== rtl/core/fixed_width_radix_formatter.sv =====
// Top level of the fixed-width radix formatter: registers, controller, datapath, digit store.
//
//   Channel  Kind         Item / register
//   s_*      stream in    one unsigned value per item
//   m_*      stream out   one ASCII character per item, tlast on the final one
//   p*       APB          radix at 0x0, digit_count at 0x4
//
// Sequence: an item is taken, then each digit takes one pass of the eight-bit-per-cycle
// divider over the ceil(VALUE_WIDTH/8) chunks of the value (four at 32 bits), or a single
// zero write once the remaining quotient is zero. The first digit is then fetched from
// the digit store, and one character leaves per cycle while m_tready is high.
// The input is taken only when the previous value's characters have all gone.
// Reset is asynchronous and active low; it restores radix 10 and digit_count 10.
// A stall on the output holds the shown character and the read pointer.
module fixed_width_radix_formatter #(
	parameter int unsigned VALUE_WIDTH = fwrf_pkg::DEF_VALUE_WIDTH,
	parameter int unsigned MAX_DIGITS  = fwrf_pkg::DEF_MAX_DIGITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream: tdata holds value from bit 0 up, zero padded to whole bytes.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// Output stream: tdata holds character in bits 6:0, bit 7 is zero.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,
	output logic                             m_tlast,
	// Configuration port.
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fwrf_pkg::PADDR_W-1:0]     paddr,
	input  logic [fwrf_pkg::REG_W-1:0]       pwdata,
	output logic [fwrf_pkg::REG_W-1:0]       prdata,
	output logic                             pready
);

	// The divider consumes the value in eight-bit chunks.
	localparam int unsigned NCHUNK = (VALUE_WIDTH + fwrf_pkg::CHUNK_W - 1) / fwrf_pkg::CHUNK_W;
	localparam int unsigned PW     = NCHUNK * fwrf_pkg::CHUNK_W;
	localparam int unsigned AW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic [fwrf_pkg::RADIX_W-1:0] eff_radix;
	logic [AW-1:0]                last_idx;
	fwrf_pkg::cmd_t               cmd;
	fwrf_pkg::sts_t               sts;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                rd_addr;
	logic                         rd_en;
	logic [fwrf_pkg::DIGIT_W-1:0] wdata;
	logic [fwrf_pkg::DIGIT_W-1:0] rdata;

	// The user must make configuration writes only while the block is idle; the block does not
	// enforce it. The effective radix and count are used straight from the registers.
	fwrf_regs #(
		.MAX_DIGITS (MAX_DIGITS),
		.AW         (AW)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.eff_radix (eff_radix),
		.last_idx  (last_idx)
	);

	fwrf_ctrl #(
		.NCHUNK (NCHUNK),
		.AW     (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.last_idx (last_idx),
		.sts      (sts),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr)
	);

	// Bits of the input above VALUE_WIDTH are padding and are not used.
	fwrf_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NCHUNK      (NCHUNK),
		.PW          (PW)
	) u_dpath (
		.clk   (clk),
		.cmd   (cmd),
		.value (s_tdata[VALUE_WIDTH-1:0]),
		.radix (eff_radix),
		.sts   (sts),
		.wdata (wdata)
	);

	// Digits are written least significant first at rising addresses and read
	// back from the top address downwards, which reverses their order.
	fwrf_ram #(
		.WIDTH (fwrf_pkg::DIGIT_W),
		.DEPTH (MAX_DIGITS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (wr_addr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// The registered read data stays put until the next read, so it is the
	// output register for the shown character.
	assign m_tdata = {1'b0, fwrf_pkg::glyph(rdata)};

endmodule

// ===== tb/fwrf_digit_checker.sv =====
// Checker for the radix formatter: tracks the registers, predicts the characters and compares them.
module fwrf_digit_checker
	import fwrf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [31:0]          s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,
	input  logic                 m_tlast,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [REG_W-1:0]     pwdata,
	input  logic [REG_W-1:0]     prdata,
	input  logic                 pready,
	output int unsigned          mismatches,
	output int unsigned          chars_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned    DIGIT_LIMIT = DEF_MAX_DIGITS;
	localparam logic [127:0]   GLYPHS      = "0123456789ABCDEF";

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_item_t;

	char_item_t         char_queue[$];
	logic [RADIX_W-1:0] radix_reg;
	logic [COUNT_W-1:0] count_reg;
	int unsigned        fault_count;

	// Every fault is printed and counted.
	task automatic log_fault(input string what);
		fault_count++;
		$display("%0t: %s", $time, what);
	endtask

	// Works out the characters of one value under the current base and width.
	task automatic queue_characters(input logic [31:0] value);
		logic [31:0]        rest;
		int unsigned        rad;
		int unsigned        cnt;
		int unsigned        base;
		int unsigned        width;
		int unsigned        d;
		logic [DIGIT_W-1:0] digits[DIGIT_LIMIT];
		char_item_t         item;
		rad   = 32'(radix_reg);
		cnt   = 32'(count_reg);
		base  = (rad < 32'(RADIX_MIN)) ? 32'(RADIX_MIN)
			: (rad > 32'(RADIX_MAX)) ? 32'(RADIX_MAX) : rad;
		width = (cnt == 0) ? 1 : (cnt > DIGIT_LIMIT) ? DIGIT_LIMIT : cnt;
		rest  = value;
		for (int i = 0; i < int'(width); i++) begin
			digits[i] = DIGIT_W'(rest % base);
			rest      = rest / base;
		end
		for (int i = int'(width) - 1; i >= 0; i--) begin
			d         = 32'(digits[i]);
			item.code = GLYPHS[(15 - d) * 8 +: CHAR_W];
			item.last = (i == 0);
			char_queue.push_back(item);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		char_item_t       want;
		logic [REG_W-1:0] readback;
		if (!arst_n) begin
			radix_reg   <= RADIX_RESET;
			count_reg   <= COUNT_RESET;
			char_queue.delete();
			fault_count = 0;
			mismatches  <= 0;
			chars_owed  <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[2]))
						REG_RADIX: radix_reg <= pwdata[RADIX_W-1:0];
						REG_COUNT: count_reg <= pwdata[COUNT_W-1:0];
					endcase
				end else begin
					readback = (reg_idx_t'(paddr[2]) == REG_RADIX) ? REG_W'(radix_reg)
						: REG_W'(count_reg);
					if (prdata !== readback) begin
						log_fault($sformatf("register read at 0x%0h: expected 0x%0h, got 0x%0h",
							paddr, readback, prdata));
					end
				end
			end
			// The oldest expectation is taken before the new value adds its own.
			if (m_tvalid && m_tready) begin
				if (char_queue.size() == 0) begin
					log_fault($sformatf("character: expected none, got 0x%02h last %0b",
						m_tdata, m_tlast));
				end else begin
					want = char_queue.pop_front();
					if (m_tdata[CHAR_W-1:0] !== want.code) begin
						log_fault($sformatf("character: expected '%c' (0x%02h), got 0x%02h",
							want.code, want.code, m_tdata[CHAR_W-1:0]));
					end
					if (m_tlast !== want.last) begin
						log_fault($sformatf("last marker: expected %0b, got %0b",
							want.last, m_tlast));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				queue_characters(s_tdata);
			end
			mismatches <= fault_count;
			chars_owed <= char_queue.size();
		end
	end

endmodule

// ===== tb/tb_fixed_width_radix_formatter.sv =====
// Testbench top for the fixed-width radix formatter: clock, reset, stimulus, back-pressure and verdict.
module tb_fixed_width_radix_formatter;
	timeunit 1ns;
	timeprecision 1ps;

	import fwrf_pkg::*;

	// Longest quiet spell that a correct run can show: a full 32-digit conversion
	// plus the long output hold, taken several times over.
	localparam int unsigned STALL_LIMIT  = 2000;
	// Worst-case time for one value to pass through once taken, with the receiver always ready.
	localparam int unsigned DRAIN_CYCLES = 2 + DEF_MAX_DIGITS + DEF_MAX_DIGITS * 4;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned IDLE_PERCENT = 38;
	localparam int unsigned PHASES       = 12;
	localparam int unsigned PHASE_ITEMS  = 19;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;    // value in bits 31:0
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;    // character in bits 6:0, bit 7 zero
	logic               m_tlast;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [REG_W-1:0]   pwdata;
	logic [REG_W-1:0]   prdata;
	logic               pready;

	int unsigned        mismatches;
	int unsigned        chars_owed;

	// steady switches idling off on both sides; hold_req asks the receiver for one long hold.
	logic               steady;
	logic               hold_req;
	logic               hold_spent;
	int unsigned        hold_left;
	int unsigned        stall_cycles;

	fixed_width_radix_formatter i_dut (.*);

	fwrf_digit_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random back-pressure, a spell of full speed and one long hold. During the
	// hold the sender keeps offering values, so the block fills up and stops taking input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_req && !hold_spent) begin
			hold_left  <= HOLD_CYCLES;
			hold_spent <= 1'b1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Watchdog: counts cycles in which neither stream moves an item.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// One APB transfer. psel stays high afterwards so that transfers can follow back to back;
	// apb_park lowers it once the sequence is over.
	task automatic apb_transfer(input logic write, input reg_idx_t idx,
		input logic [REG_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_park();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_back();
		apb_transfer(1'b0, REG_RADIX, '0);
		apb_transfer(1'b0, REG_COUNT, '0);
	endtask

	// Writes both registers with random junk above the used bits, then reads them back.
	// Only called while the block is idle.
	task automatic set_format(input logic [RADIX_W-1:0] radix, input logic [COUNT_W-1:0] count);
		apb_transfer(1'b1, REG_RADIX, ($urandom() & ~REG_W'(5'h1F)) | REG_W'(radix));
		apb_transfer(1'b1, REG_COUNT, ($urandom() & ~REG_W'(6'h3F)) | REG_W'(count));
		read_back();
		apb_park();
	endtask

	// Offers one value, with random gaps before it unless the run is in its steady spell.
	// tvalid is only lowered in a gap, so back-to-back items keep it high.
	task automatic send_value(input logic [31:0] v);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering and waits until every predicted character has come out. The first
	// edge lets the checker count the value that was taken last.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chars_owed != 0) @(posedge clk);
	endtask

	// Mix of small numbers, runs of ones of every length and fully random words.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 255);
			1:       return 32'hFFFF_FFFF >> $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [RADIX_W-1:0] radix;
		logic [COUNT_W-1:0] count;
		clk        = 1'b0;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		m_tready   <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		steady     <= 1'b0;
		hold_req   <= 1'b0;
		hold_spent <= 1'b0;
		hold_left  <= 0;
		stall_cycles <= 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First the reset format, base ten over ten digits, which also fits
		// the widest 32-bit value exactly.
		read_back();
		apb_park();
		send_value(32'h0000_0000);
		send_value(32'hFFFF_FFFF);
		send_value(32'h0000_0001);
		send_value(32'h8000_0000);
		send_value(32'd1234567890);
		send_value(32'd1000000000);
		drain();
		// Hexadecimal brings in every letter digit.
		set_format(5'd16, 6'd8);
		send_value(32'hFEDC_BA98);
		send_value(32'h0123_4567);
		send_value(32'h89AB_CDEF);
		drain();
		// Binary over the full width: alternating bits take every value of every bit.
		set_format(5'd2, 6'd32);
		send_value(32'hAAAA_AAAA);
		send_value(32'h5555_5555);
		drain();
		// Too narrow a field: high digits are dropped.
		set_format(5'd10, 6'd3);
		send_value(32'd12345);
		drain();
		// Base zero falls back to binary, and a zero digit count still gives one character.
		set_format(5'd0, 6'd0);
		send_value(32'd3);
		drain();
		// Base one also falls back to binary.
		set_format(5'd1, 6'd1);
		send_value(32'd2);
		drain();
		// Oversized base and digit count saturate at sixteen and at the digit limit.
		set_format(5'd31, 6'd63);
		send_value(32'hFFFF_FFFF);
		drain();
		set_format(5'd17, 6'd33);
		send_value(32'h1234_5678);
		drain();

		// Random part: each phase takes a new format, the first few at the extremes.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin radix = 5'd2;  count = 6'd32; end
				1: begin radix = 5'd16; count = 6'd1;  end
				2: begin radix = 5'd0;  count = 6'd63; end
				3: begin radix = 5'd31; count = 6'd0;  end
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						radix = RADIX_W'($urandom_range(0, 31));
						count = COUNT_W'($urandom_range(0, 63));
					end else begin
						radix = RADIX_W'($urandom_range(2, 16));
						count = COUNT_W'($urandom_range(1, 32));
					end
				end
			endcase
			set_format(radix, count);
			// One phase runs at full speed on both sides; a later one carries the long hold.
			steady <= (p == 4);
			if (p == 7) begin
				hold_req <= 1'b1;
			end
			repeat (PHASE_ITEMS) send_value(pick_value());
			drain();
		end

		// Give any stray character time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && chars_owed == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
